>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/cppc_pkg.sv
package cppc_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 2;
    localparam int FRAC_W = 16;
    // Accumulator holds Y*2^16 plus the largest chroma term with sign
    localparam int ACC_W  = 27;
    localparam int DIFF_W = BYTE_W + 2;

    localparam logic [POS_W-1:0] UYVY_LAST_POS = 2'd3;
    localparam logic [POS_W-1:0] RGB_LAST_POS  = 2'd2;

    localparam logic signed [DIFF_W-1:0] CHROMA_OFS = 10'sd128;

    localparam logic signed [ACC_W-1:0] COEF_CR_R = 27'sd92176;
    localparam logic signed [ACC_W-1:0] COEF_CB_G = 27'sd22643;
    localparam logic signed [ACC_W-1:0] COEF_CR_G = 27'sd46983;
    localparam logic signed [ACC_W-1:0] COEF_CB_B = 27'sd116589;

    localparam logic [BYTE_W-1:0] CHAN_MAX = 8'hff;
    localparam logic [BYTE_W-1:0] CHAN_MIN = 8'h00;

    typedef enum logic
    {
        FMT_UYVY  = 1'b0,
        FMT_RGB24 = 1'b1
    } fmt_t;

    typedef struct packed
    {
        fmt_t              fmt;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
    } grp_t;

    typedef struct packed
    {
        logic valid;
        grp_t data;
    } grp_link_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              last_of_run;
    } pix_t;

    // Floor by the shift, then clamp to 0..255
    function automatic logic [BYTE_W-1:0] clip_to_byte(input logic signed [ACC_W-1:0] acc);
        logic [BYTE_W-1:0] res;
        if (acc[ACC_W-1])
        begin
            res = CHAN_MIN;
        end
        else if (|acc[ACC_W-2:FRAC_W+BYTE_W])
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = acc[FRAC_W+BYTE_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/cppc_in_if.sv
interface cppc_in_if;
    import cppc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              sync;

    modport source (output valid, output byte_in, output sync, input ready);
    modport sink   (input valid, input byte_in, input sync, output ready);
endinterface

>>> hw/rtl/cppc_out_if.sv
interface cppc_out_if;
    import cppc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              last_of_run;

    modport source (output valid, output red, output green, output blue,
                    output last_of_run, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_run, output ready);
endinterface

>>> hw/rtl/cppc_unpack.sv
`include "assert_macros.svh"

module cppc_unpack
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    cppc_in_if.sink             byte_stream,
    output cppc_pkg::grp_link_t grp,
    input  logic                grp_take
);
    import cppc_pkg::*;

    fmt_t              fmt_reg;
    fmt_t              fmt_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] held_reg [3];
    logic              grp_valid_reg;
    logic              grp_valid_next;
    grp_t              grp_data_reg;

    logic              in_fire;
    logic [POS_W-1:0]  pos_eff;
    logic              completes;
    logic              at_end;

    assign in_fire = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        pos_eff = byte_stream.sync ? '0 : pos_reg;
        if (fmt_reg == FMT_RGB24)
        begin
            completes = (pos_eff >= RGB_LAST_POS);
            at_end    = (pos_reg >= RGB_LAST_POS);
        end
        else
        begin
            completes = (pos_eff == UYVY_LAST_POS);
            at_end    = (pos_reg == UYVY_LAST_POS);
        end
    end

    // Stall only a beat that may close a group while the previous group still waits
    assign byte_stream.ready = !grp_valid_reg || !at_end;

    always_comb
    begin
        fmt_next = fmt_reg;
        pos_next = pos_reg;
        if (cfg_we)
        begin
            fmt_next = fmt_t'(cfg_wdata);
            pos_next = '0;
        end
        else if (in_fire)
        begin
            pos_next = completes ? '0 : POS_W'(pos_eff + 2'd1);
        end
        grp_valid_next = (grp_valid_reg && !grp_take) || (in_fire && completes);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_UYVY;
            pos_reg       <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            fmt_reg       <= fmt_next;
            pos_reg       <= pos_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !completes)
        begin
            held_reg[pos_eff] <= byte_stream.byte_in;
        end
        if (in_fire && completes)
        begin
            grp_data_reg.fmt <= fmt_reg;
            grp_data_reg.b0  <= held_reg[0];
            grp_data_reg.b1  <= held_reg[1];
            grp_data_reg.b2  <= held_reg[2];
            grp_data_reg.b3  <= byte_stream.byte_in;
        end
    end

    assign grp.valid = grp_valid_reg;
    assign grp.data  = grp_data_reg;

    `ASSERT_CLK(a_no_group_overwrite, clk, rst_n, (in_fire && completes) |-> !grp_valid_reg)
    `ASSERT_CLK(a_rgb_pos_bound, clk, rst_n, (fmt_reg == FMT_RGB24) |-> (pos_reg != UYVY_LAST_POS))
    `ASSERT_CLK(a_group_holds, clk, rst_n, (grp_valid_reg && !grp_take) |=> (grp_valid_reg && $stable(grp_data_reg)))

endmodule

>>> hw/rtl/cppc_convert.sv
module cppc_convert
(
    input  logic [cppc_pkg::BYTE_W-1:0] y,
    input  logic [cppc_pkg::BYTE_W-1:0] cb,
    input  logic [cppc_pkg::BYTE_W-1:0] cr,
    output logic [cppc_pkg::BYTE_W-1:0] red,
    output logic [cppc_pkg::BYTE_W-1:0] green,
    output logic [cppc_pkg::BYTE_W-1:0] blue
);
    import cppc_pkg::*;

    logic signed [DIFF_W-1:0] db;
    logic signed [DIFF_W-1:0] dr;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_r;
    logic signed [ACC_W-1:0]  acc_g;
    logic signed [ACC_W-1:0]  acc_b;

    always_comb
    begin
        db    = $signed({2'b00, cb}) - CHROMA_OFS;
        dr    = $signed({2'b00, cr}) - CHROMA_OFS;
        base  = $signed({{(ACC_W-BYTE_W-FRAC_W){1'b0}}, y, {FRAC_W{1'b0}}});
        acc_r = base + COEF_CR_R * ACC_W'(dr);
        acc_g = base - COEF_CB_G * ACC_W'(db) - COEF_CR_G * ACC_W'(dr);
        acc_b = base + COEF_CB_B * ACC_W'(db);
        red   = clip_to_byte(acc_r);
        green = clip_to_byte(acc_g);
        blue  = clip_to_byte(acc_b);
    end

endmodule

>>> hw/rtl/cppc_out_buf.sv
`include "assert_macros.svh"

module cppc_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  cppc_pkg::grp_link_t grp,
    output logic                grp_take,
    cppc_out_if.source          pixel_stream
);
    import cppc_pkg::*;

    localparam logic [1:0] CNT_PAIR = 2'd2;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_BAD  = 2'd3;

    pix_t       slot0_reg;
    pix_t       slot1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    pix_t              conv0;
    pix_t              conv1;
    pix_t              load0;
    logic              out_fire;

    cppc_convert u_conv0
    (
        .y     (grp.data.b1),
        .cb    (grp.data.b0),
        .cr    (grp.data.b2),
        .red   (conv0.red),
        .green (conv0.green),
        .blue  (conv0.blue)
    );

    cppc_convert u_conv1
    (
        .y     (grp.data.b3),
        .cb    (grp.data.b0),
        .cr    (grp.data.b2),
        .red   (conv1.red),
        .green (conv1.green),
        .blue  (conv1.blue)
    );

    assign conv0.last_of_run = 1'b0;
    assign conv1.last_of_run = 1'b1;

    always_comb
    begin
        out_fire = pixel_stream.valid && pixel_stream.ready;
        // Take a group once the last waiting pixel leaves
        grp_take = grp.valid && ((cnt_reg == '0) || ((cnt_reg == CNT_ONE) && out_fire));
        if (grp.data.fmt == FMT_RGB24)
        begin
            load0.red         = grp.data.b0;
            load0.green       = grp.data.b1;
            load0.blue        = grp.data.b3;
            load0.last_of_run = 1'b1;
        end
        else
        begin
            load0 = conv0;
        end
        if (grp_take)
        begin
            cnt_next = (grp.data.fmt == FMT_RGB24) ? CNT_ONE : CNT_PAIR;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_take)
        begin
            slot0_reg <= load0;
            slot1_reg <= conv1;
        end
        else if (out_fire && (cnt_reg == CNT_PAIR))
        begin
            // advance the second pixel of the pair
            slot0_reg <= slot1_reg;
        end
    end

    assign pixel_stream.valid       = (cnt_reg != '0);
    assign pixel_stream.red         = slot0_reg.red;
    assign pixel_stream.green       = slot0_reg.green;
    assign pixel_stream.blue        = slot0_reg.blue;
    assign pixel_stream.last_of_run = slot0_reg.last_of_run;

    `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_reg == CNT_BAD)
    `ASSERT_CLK(a_pair_order, clk, rst_n, (cnt_reg == CNT_PAIR) |-> (!slot0_reg.last_of_run && slot1_reg.last_of_run))
    `ASSERT_CLK(a_uyvy_pair, clk, rst_n, (grp_take && (grp.data.fmt == FMT_UYVY)) |=> (cnt_reg == CNT_PAIR))

endmodule

>>> hw/rtl/camera_pixel_unpack_convert_top.sv
// The first pixel of a group passes through the group register and then the result register.
// Unless stalled: one byte per cycle in; one pixel per cycle out from a two-pixel result register.
// A group waits in a single group register; a beat at the closing position stalls while it is full.
// Reset (rst_n low, asynchronous): format UYVY, grouping at the first byte, no pixel pending.
// A pixel_format write also restarts grouping.
module camera_pixel_unpack_convert_top
(
    input  logic       clk,
    input  logic       rst_n,
    cppc_in_if.sink    byte_stream,
    cppc_out_if.source pixel_stream,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import cppc_pkg::*;

    grp_link_t grp;
    logic      grp_take;

    cppc_unpack u_unpack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_stream (byte_stream),
        .grp         (grp),
        .grp_take    (grp_take)
    );

    cppc_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp          (grp),
        .grp_take     (grp_take),
        .pixel_stream (pixel_stream)
    );

endmodule
